[hw/rtl/dlm_pkg.sv]
// dlm_pkg: shared types and constants for the dense layer matrix-vector block.
// Holds the input and result transaction structs, item kind codes and the
// controller-to-datapath command struct. No dependencies.
package dlm_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 12;
    localparam int IDX_W     = 4;
    localparam int MAX_ROWS  = 16;

    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_BIAS   = 2'd1;
    localparam logic [1:0] KIND_INPUT  = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [DATA_W-1:0] out_value;
        logic                     clipped;
        logic                     end_of_vector;
    } out_item_t;

    typedef struct packed {
        logic issue;
        logic first;
        logic bias_add;
        logic emit;
        logic eov;
    } dp_cmd_t;

endpackage

[hw/rtl/dense_layer_matvec.sv]
// dense_layer_matvec: top level of the Q4.12 fully connected layer.
// Joins the sweep controller and the MAC datapath. Depends on dlm_pkg,
// dlm_ctrl and dlm_datapath.
//
//   channel   handshake                 payload
//   input     start, busy               item   (in_item_t)
//   result    result_valid (strobe)     result (out_item_t)
//
// Weight, bias and plain input writes leave busy low.
// An input element with last set starts a sweep over min(NUM_OUTPUTS, 16)
// rows: each output row runs through issue, drain A, drain B, bias and emit
// on the single shared multiply-accumulate unit, one weight read per cycle
// from the weight memory while issuing. busy stays high for the whole sweep.
// Reset clears control only; the stores hold garbage until written.
// Each result shows for one cycle; the receiver cannot stall.
module dense_layer_matvec #(
    parameter int NUM_INPUTS  = 16,
    parameter int NUM_OUTPUTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dlm_pkg::in_item_t  item,
    output logic               result_valid,
    output dlm_pkg::out_item_t result
);
    import dlm_pkg::*;

    localparam int COL_W   = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int WADDR_W = (NUM_OUTPUTS * NUM_INPUTS > 1)
                             ? $clog2(NUM_OUTPUTS * NUM_INPUTS) : 1;

    logic                accept;
    logic                sweep_go;
    dp_cmd_t             cmd;
    logic [COL_W-1:0]    rd_col;
    logic [WADDR_W-1:0]  rd_addr;
    logic [IDX_W-1:0]    row;

    assign accept   = start && !busy;
    assign sweep_go = accept && (item.kind == KIND_INPUT) && item.last;

    dlm_ctrl #(
        .NUM_INPUTS  (NUM_INPUTS),
        .NUM_OUTPUTS (NUM_OUTPUTS),
        .COL_W       (COL_W),
        .WADDR_W     (WADDR_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sweep_go (sweep_go),
        .busy     (busy),
        .cmd      (cmd),
        .rd_col   (rd_col),
        .rd_addr  (rd_addr),
        .row      (row)
    );

    dlm_datapath #(
        .NUM_INPUTS  (NUM_INPUTS),
        .NUM_OUTPUTS (NUM_OUTPUTS),
        .COL_W       (COL_W),
        .WADDR_W     (WADDR_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (item),
        .cmd          (cmd),
        .rd_col       (rd_col),
        .rd_addr      (rd_addr),
        .row          (row),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTH
    a_sweep_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_go |=> busy)
        else $error("sweep start did not raise busy");

    a_result_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe outside a sweep");

    a_eov_ends_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.end_of_vector) |-> !busy)
        else $error("sweep still running after end of vector");

    a_results_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("back-to-back result strobes");
`endif

endmodule

[hw/rtl/dlm_ctrl.sv]
// dlm_ctrl: sweep controller for the dense layer block.
// Walks rows and columns, issues weight reads and sequences bias add and
// result emission. Depends on dlm_pkg.
module dlm_ctrl #(
    parameter int NUM_INPUTS  = 16,
    parameter int NUM_OUTPUTS = 16,
    parameter int COL_W       = 4,
    parameter int WADDR_W     = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sweep_go,
    output logic                       busy,
    output dlm_pkg::dp_cmd_t           cmd,
    output logic [COL_W-1:0]           rd_col,
    output logic [WADDR_W-1:0]         rd_addr,
    output logic [dlm_pkg::IDX_W-1:0]  row
);
    import dlm_pkg::*;

    localparam int NROW = (NUM_OUTPUTS < MAX_ROWS) ? NUM_OUTPUTS : MAX_ROWS;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(NUM_INPUTS - 1);
    localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(NROW - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_BIAS,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic [COL_W-1:0]     col_reg;
    logic [WADDR_W-1:0]   waddr_reg;
    logic [IDX_W-1:0]     row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            waddr_reg <= '0;
            row_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sweep_go)
                    begin
                        state_reg <= ST_ISSUE;
                        col_reg   <= '0;
                        waddr_reg <= '0;
                        row_reg   <= '0;
                    end
                end
                ST_ISSUE:
                begin
                    waddr_reg <= waddr_reg + 1'b1;
                    if (col_reg == COL_LAST)
                    begin
                        col_reg   <= '0;
                        state_reg <= ST_DRAIN_A;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                ST_DRAIN_A:
                begin
                    state_reg <= ST_DRAIN_B;
                end
                ST_DRAIN_B:
                begin
                    state_reg <= ST_BIAS;
                end
                ST_BIAS:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (row_reg == ROW_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= ST_ISSUE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.issue    = (state_reg == ST_ISSUE);
        cmd.first    = (state_reg == ST_ISSUE) && (col_reg == '0);
        cmd.bias_add = (state_reg == ST_BIAS);
        cmd.emit     = (state_reg == ST_EMIT);
        cmd.eov      = (state_reg == ST_EMIT) && (row_reg == ROW_LAST);
    end

    assign busy    = (state_reg != ST_IDLE);
    assign rd_col  = col_reg;
    assign rd_addr = waddr_reg;
    assign row     = row_reg;

endmodule

[hw/rtl/dlm_datapath.sv]
// dlm_datapath: storage and multiply-accumulate datapath of the dense layer.
// Holds weight, bias and input memories, the MAC pipeline, bias add, rounding
// and saturation, and the result register. Depends on dlm_pkg.
module dlm_datapath #(
    parameter int NUM_INPUTS  = 16,
    parameter int NUM_OUTPUTS = 16,
    parameter int COL_W       = 4,
    parameter int WADDR_W     = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  dlm_pkg::in_item_t          item,
    input  dlm_pkg::dp_cmd_t           cmd,
    input  logic [COL_W-1:0]           rd_col,
    input  logic [WADDR_W-1:0]         rd_addr,
    input  logic [dlm_pkg::IDX_W-1:0]  row,
    output logic                       result_valid,
    output dlm_pkg::out_item_t         result
);
    import dlm_pkg::*;

    localparam int BIAS_DEPTH = (NUM_OUTPUTS < MAX_ROWS) ? NUM_OUTPUTS : MAX_ROWS;
    localparam int BIAS_W     = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
    localparam int WDEPTH     = NUM_OUTPUTS * NUM_INPUTS;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W + $clog2(NUM_INPUTS + 1) + 2;

    localparam logic signed [ACC_W-1:0] ROUND_K = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (DATA_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    logic signed [DATA_W-1:0] weight_mem [WDEPTH];
    logic signed [DATA_W-1:0] bias_mem   [BIAS_DEPTH];
    logic signed [DATA_W-1:0] input_mem  [NUM_INPUTS];

    logic                     weight_we;
    logic                     bias_we;
    logic                     input_we;
    logic [WADDR_W-1:0]       weight_waddr;

    logic signed [DATA_W-1:0] wgt_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] bias_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  sum_reg;
    logic                     v1_reg;
    logic                     f1_reg;
    logic                     v2_reg;
    logic                     f2_reg;
    logic                     result_valid_reg;
    out_item_t                result_reg;

    logic signed [ACC_W-1:0]  shifted;
    logic signed [ACC_W-1:0]  sat_val;
    logic                     clip;

    assign weight_we = accept && (item.kind == KIND_WEIGHT)
                       && (32'(item.row) < NUM_OUTPUTS) && (32'(item.col) < NUM_INPUTS);
    assign bias_we   = accept && (item.kind == KIND_BIAS) && (32'(item.row) < NUM_OUTPUTS);
    assign input_we  = accept && (item.kind == KIND_INPUT) && (32'(item.col) < NUM_INPUTS);
    assign weight_waddr = WADDR_W'(item.row) * WADDR_W'(NUM_INPUTS) + WADDR_W'(item.col);

    always_ff @(posedge clk)
    begin
        if (weight_we)
        begin
            weight_mem[weight_waddr] <= item.value;
        end
        if (bias_we)
        begin
            bias_mem[BIAS_W'(item.row)] <= item.value;
        end
        if (input_we)
        begin
            input_mem[COL_W'(item.col)] <= item.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            wgt_reg  <= weight_mem[rd_addr];
            x_reg    <= input_mem[rd_col];
            bias_reg <= bias_mem[BIAS_W'(row)];
        end
        prod_reg <= wgt_reg * x_reg;
        if (v2_reg)
        begin
            acc_reg <= f2_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.bias_add)
        begin
            sum_reg <= acc_reg + (ACC_W'(bias_reg) <<< FRAC_BITS) + ROUND_K;
        end
        if (cmd.emit)
        begin
            result_reg.out_index     <= row;
            result_reg.out_value     <= sat_val[DATA_W-1:0];
            result_reg.clipped       <= clip;
            result_reg.end_of_vector <= cmd.eov;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            f1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            f2_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg           <= cmd.issue;
            f1_reg           <= cmd.first;
            v2_reg           <= v1_reg;
            f2_reg           <= f1_reg;
            result_valid_reg <= cmd.emit;
        end
    end

    always_comb
    begin
        shifted = sum_reg >>> FRAC_BITS;
        clip    = 1'b0;
        sat_val = shifted;
        if (shifted > SAT_MAX)
        begin
            sat_val = SAT_MAX;
            clip    = 1'b1;
        end
        else if (shifted < SAT_MIN)
        begin
            sat_val = SAT_MIN;
            clip    = 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[test/tb_activation_check.sv]
// tb_activation_check: watches the item and result channels of dense_layer_matvec,
// keeps its own weight, bias and sample stores and checks every activation sum.
// Depends on dlm_pkg.
module tb_activation_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  dlm_pkg::in_item_t  item,
    input  logic               result_valid,
    input  dlm_pkg::out_item_t result,
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import dlm_pkg::*;

    localparam longint SAT_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
    localparam longint SAT_MIN = -SAT_MAX - 1;

    logic signed [DATA_W-1:0] weight_mem [MAX_ROWS][MAX_ROWS];
    logic signed [DATA_W-1:0] bias_mem   [MAX_ROWS];
    logic signed [DATA_W-1:0] sample_mem [MAX_ROWS];
    out_item_t                activation_q [$];
    int                       n_bad = 0;

    task automatic queue_activations();
        longint    acc;
        longint    sum;
        out_item_t act;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            acc = longint'(bias_mem[r]) <<< FRAC_BITS;
            for (int c = 0; c < MAX_ROWS; c++)
                acc += longint'(weight_mem[r][c]) * longint'(sample_mem[c]);
            sum = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            act.out_index = IDX_W'(r);
            act.clipped   = 1'b0;
            if (sum > SAT_MAX)
            begin
                sum         = SAT_MAX;
                act.clipped = 1'b1;
            end
            else if (sum < SAT_MIN)
            begin
                sum         = SAT_MIN;
                act.clipped = 1'b1;
            end
            act.out_value     = sum[DATA_W-1:0];
            act.end_of_vector = (r == MAX_ROWS - 1);
            activation_q.push_back(act);
        end
    endtask

    task automatic note_mismatch(input string what, input out_item_t exp, input out_item_t got);
        n_bad++;
        if (n_bad <= 10)
            $display("%0t %s: expected idx %0d val %0d clip %0b eov %0b,",
                     $time, what, exp.out_index, exp.out_value, exp.clipped,
                     exp.end_of_vector,
                     " got idx %0d val %0d clip %0b eov %0b",
                     got.out_index, got.out_value, got.clipped, got.end_of_vector);
    endtask

    always @(posedge clk)
    begin
        out_item_t exp;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (activation_q.size() == 0)
                    note_mismatch("unexpected activation", '0, result);
                else
                begin
                    exp = activation_q.pop_front();
                    if (result.out_index !== exp.out_index ||
                        result.out_value !== exp.out_value ||
                        result.clipped !== exp.clipped ||
                        result.end_of_vector !== exp.end_of_vector)
                        note_mismatch("activation mismatch", exp, result);
                end
            end
            if (start && !busy)
            begin
                case (item.kind)
                    KIND_WEIGHT: weight_mem[item.row][item.col] = item.value;
                    KIND_BIAS:   bias_mem[item.row] = item.value;
                    KIND_INPUT:
                    begin
                        sample_mem[item.col] = item.value;
                        if (item.last)
                            queue_activations();
                    end
                    default: ;
                endcase
            end
        end
        mismatches  <= n_bad;
        outstanding <= activation_q.size();
    end

endmodule

[test/tb.sv]
// tb: stimulus and verdict for dense_layer_matvec. Preloads every store, runs
// directed saturation and rounding sweeps, then random traffic under idle phases.
// Depends on dlm_pkg, dense_layer_matvec and tb_activation_check.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dlm_pkg::*;

    localparam logic [1:0]               KIND_UNUSED    = 2'd3;
    localparam logic signed [DATA_W-1:0] Q_MIN          = 16'sh8000;
    localparam logic signed [DATA_W-1:0] Q_MAX          = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] Q_ZERO         = 16'sh0000;
    localparam logic signed [DATA_W-1:0] Q_LSB          = 16'sh0001;
    localparam logic signed [DATA_W-1:0] Q_HALF         = 16'sh0800;
    localparam logic signed [DATA_W-1:0] Q_NEG_HALF     = 16'shF800;
    localparam int                       SWEEP_CYCLES   = MAX_ROWS * (MAX_ROWS + 4);
    localparam int                       WATCHDOG_LIMIT = 5000;
    localparam int                       PHASE_ITEMS    = 25;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    in_item_t  item  = '0;
    logic      result_valid;
    out_item_t result;
    int        mismatches;
    int        outstanding;
    int        quiet_cycles = 0;
    int        idle_pct = 0;
    int        phase_idle [4] = '{0, 88, 24, 0};

    dense_layer_matvec u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    tb_activation_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic in_item_t build_item(input logic [1:0] kind, input int row, input int col,
                                            input logic signed [DATA_W-1:0] value,
                                            input logic last);
        in_item_t it;
        it.kind  = kind;
        it.row   = row[IDX_W-1:0];
        it.col   = col[IDX_W-1:0];
        it.value = value;
        it.last  = last;
        return it;
    endfunction

    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return Q_ZERO;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_item();
        int         pick;
        logic [1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            kind = KIND_WEIGHT;
        else if (pick < 55)
            kind = KIND_BIAS;
        else if (pick < 95)
            kind = KIND_INPUT;
        else
            kind = KIND_UNUSED;
        return build_item(kind, $urandom_range(0, 15), $urandom_range(0, 15), random_value(),
                          $urandom_range(0, 7) == 0);
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain_activations();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        in_item_t it;
        int       counted;
        logic signed [DATA_W-1:0] w;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every store before the first sweep
        for (int r = 0; r < MAX_ROWS; r++)
            for (int c = 0; c < MAX_ROWS; c++)
            begin
                if (r == 0)
                    w = Q_MIN;
                else if (r == 1)
                    w = Q_MAX;
                else if (r == 2)
                    w = (c == 0) ? Q_LSB : Q_ZERO;
                else
                    w = random_value();
                send_item(build_item(KIND_WEIGHT, r, c, w, 1'b0));
            end
        for (int r = 0; r < MAX_ROWS; r++)
            send_item(build_item(KIND_BIAS, r, 0,
                                 r == 0 ? Q_MAX : r == 1 ? Q_MIN : r == 2 ? Q_ZERO : random_value(),
                                 1'b0));
        for (int c = 0; c < MAX_ROWS; c++)
            send_item(build_item(KIND_INPUT, 0, c, Q_MIN, 1'b0));

        // saturation both ways, then rounding of a half in both signs
        send_item(build_item(KIND_INPUT, 0, 0, Q_MIN, 1'b1));
        send_item(build_item(KIND_INPUT, 0, 0, Q_HALF, 1'b1));
        send_item(build_item(KIND_INPUT, 0, 0, Q_NEG_HALF, 1'b1));
        send_item(build_item(KIND_UNUSED, 15, 15, Q_MAX, 1'b1));
        send_item(build_item(KIND_WEIGHT, 3, 3, Q_MAX, 1'b1));
        send_item(build_item(KIND_BIAS, 15, 0, Q_MIN, 1'b1));
        send_item(build_item(KIND_WEIGHT, 15, 15, Q_MIN, 1'b0));
        send_item(build_item(KIND_INPUT, 0, 15, Q_MAX, 1'b0));
        send_item(build_item(KIND_INPUT, 0, 7, Q_ZERO, 1'b0));
        send_item(build_item(KIND_INPUT, 15, 0, Q_MAX, 1'b1));

        for (int p = 0; p < 4; p++)
        begin
            drain_activations();
            idle_pct = phase_idle[p];
            counted  = 0;
            while (counted < PHASE_ITEMS)
            begin
                it = random_item();
                send_item(it);
                if (it.kind != KIND_UNUSED)
                    counted++;
            end
        end

        drain_activations();
        repeat (SWEEP_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[dense_layer_matvec.f]
hw/rtl/dlm_pkg.sv
hw/rtl/dlm_ctrl.sv
hw/rtl/dlm_datapath.sv
hw/rtl/dense_layer_matvec.sv
test/tb_activation_check.sv
test/tb.sv
